[hdl/line_ending_converter_macros.svh]
// Assertion macros for the checker file lec_checker.sv.
`ifndef LINE_ENDING_CONVERTER_MACROS_SVH
`define LINE_ENDING_CONVERTER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define LEC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/lec_pkg.sv]
package lec_pkg;

  // Character codes
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_FF    = 8'h0C;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // Line ending conventions
  localparam logic [1:0] EOL_NONE = 2'd0;
  localparam logic [1:0] EOL_UNIX = 2'd1;
  localparam logic [1:0] EOL_DOS  = 2'd2;
  localparam logic [1:0] EOL_MAC  = 2'd3;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_EOL_MODE  = 2'd1;
  localparam logic [1:0] REG_STRIP     = 2'd2;

  localparam int ADDR_W = 4;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       direction;
    logic [1:0] eol_mode;
    logic       strip_controls;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       pending_next;
  } dec_t;

  // Control bytes that the read filter removes
  function automatic logic is_stripped(input logic [7:0] b);
    return (b < CHR_SPACE) && (b != CHR_TAB) && (b != CHR_LF) && (b != CHR_FF);
  endfunction

endpackage

[hdl/line_ending_converter.sv]
// Line ending converter: one stream byte in, zero to two bytes out.
// Input channel item_valid / item_stall / item carries data_byte and
// end_of_stream; a transfer happens when item_valid is high and item_stall low.
// Output channel result_valid / result_stall / result carries out_byte and
// run_last, which marks the last byte produced by one input byte.
// Registers on the APB port: direction at 0x0, eol_mode at 0x4,
// strip_controls at 0x8. Write them only while the stream is idle.
// A byte accepted while the result queue is empty is shown on result in the
// cycle after it is accepted.
// Throughput: one input byte per cycle while each byte gives at most one
// result and result_stall is low. The four-entry result queue drains one
// byte per cycle while result_stall is low, so a run of bytes that expand to
// two results (LF to CR LF in dos write) cannot be taken on every cycle;
// item_stall is high while more than two entries are held.
// Reset clears the registers, the held CR and the result queue. A stalled
// result holds its value; the queue keeps accepting until it holds more than two.
module line_ending_converter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lec_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  lec_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output lec_pkg::result_t           result
);

  localparam int PW = lec_pkg::QPTR_W;
  localparam int CW = lec_pkg::QCNT_W;

  lec_pkg::cfg_t    cfg;
  logic             pending_cr;
  lec_pkg::dec_t    dec;
  lec_pkg::result_t queue [lec_pkg::QDEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             accept;
  logic             pop;
  logic             cfg_write;
  logic [1:0]       num_acc;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        lec_pkg::REG_DIRECTION: cfg.direction      <= pwdata[0];
        lec_pkg::REG_EOL_MODE:  cfg.eol_mode       <= pwdata[1:0];
        lec_pkg::REG_STRIP:     cfg.strip_controls <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      lec_pkg::REG_DIRECTION: prdata[0]   = cfg.direction;
      lec_pkg::REG_EOL_MODE:  prdata[1:0] = cfg.eol_mode;
      lec_pkg::REG_STRIP:     prdata[0]   = cfg.strip_controls;
      default:                prdata      = '0;
    endcase
  end

  lec_decode u_decode (
    .cfg     (cfg),
    .item    (item),
    .pending (pending_cr),
    .dec     (dec)
  );

  // Handshakes: take a byte only with room for two results
  assign item_stall   = (count > CW'(2));
  assign accept       = item_valid & ~item_stall;
  assign result_valid = (count != '0);
  assign pop          = result_valid & ~result_stall;
  assign result       = queue[rptr];
  assign num_acc      = accept ? dec.num : 2'd0;
  assign count_next   = count + CW'(num_acc) - CW'(pop);

  // Advance pointers, count and the held CR
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      rptr       <= '0;
      count      <= '0;
      pending_cr <= 1'b0;
    end else begin
      wptr  <= wptr + PW'(num_acc);
      rptr  <= rptr + PW'(pop);
      count <= count_next;
      if (accept) pending_cr <= dec.pending_next;
    end
  end

  // Store results of the accepted byte
  always_ff @(posedge clk) begin
    if (num_acc != 2'd0) begin
      queue[wptr].out_byte <= dec.byte0;
      queue[wptr].run_last <= (num_acc == 2'd1);
    end
    if (num_acc == 2'd2) begin
      queue[wptr + PW'(1)].out_byte <= dec.byte1;
      queue[wptr + PW'(1)].run_last <= 1'b1;
    end
  end

endmodule

[hdl/lec_decode.sv]
module lec_decode (
  input  lec_pkg::cfg_t  cfg,
  input  lec_pkg::item_t item,
  input  logic           pending,
  output lec_pkg::dec_t  dec
);

  logic       v0, v1, v2;
  logic [7:0] c0, c1, c2;
  logic       pend_nx;
  logic       filt;
  logic [7:0] b;

  assign b    = item.data_byte;
  assign filt = ~cfg.direction & cfg.strip_controls;

  // Build up to three candidate bytes in emit order
  always_comb begin
    v0 = 1'b0;
    v1 = 1'b0;
    v2 = 1'b0;
    c0 = b;
    c1 = b;
    c2 = lec_pkg::CHR_CR;
    pend_nx = pending;
    if (cfg.direction) begin
      if (b == lec_pkg::CHR_LF && cfg.eol_mode == lec_pkg::EOL_DOS) begin
        v0 = 1'b1;
        c0 = lec_pkg::CHR_CR;
        v1 = 1'b1;
        c1 = lec_pkg::CHR_LF;
      end else if (b == lec_pkg::CHR_LF && cfg.eol_mode == lec_pkg::EOL_MAC) begin
        v0 = 1'b1;
        c0 = lec_pkg::CHR_CR;
      end else begin
        v0 = 1'b1;
      end
    end else if (cfg.eol_mode == lec_pkg::EOL_DOS) begin
      if (pending && b == lec_pkg::CHR_LF) begin
        v0 = 1'b1;
        c0 = lec_pkg::CHR_LF;
        pend_nx = 1'b0;
      end else begin
        v0 = pending;
        c0 = lec_pkg::CHR_CR;
        pend_nx = (b == lec_pkg::CHR_CR);
        v1 = (b != lec_pkg::CHR_CR);
      end
      // Flush a held CR at end of stream
      if (item.end_of_stream && pend_nx) begin
        v2 = 1'b1;
        pend_nx = 1'b0;
      end
    end else if (cfg.eol_mode == lec_pkg::EOL_MAC) begin
      v0 = 1'b1;
      c0 = (b == lec_pkg::CHR_CR) ? lec_pkg::CHR_LF : b;
    end else begin
      v0 = 1'b1;
    end
    // Drop filtered control bytes
    if (filt && lec_pkg::is_stripped(c0)) v0 = 1'b0;
    if (filt && lec_pkg::is_stripped(c1)) v1 = 1'b0;
    if (filt && lec_pkg::is_stripped(c2)) v2 = 1'b0;
  end

  // Pack surviving bytes, keep at most two
  always_comb begin
    dec.pending_next = pend_nx;
    dec.byte0 = c0;
    dec.byte1 = c1;
    dec.num   = 2'd0;
    if (v0) begin
      dec.byte0 = c0;
      if (v1) begin
        dec.byte1 = c1;
        dec.num   = 2'd2;
      end else if (v2) begin
        dec.byte1 = c2;
        dec.num   = 2'd2;
      end else begin
        dec.num = 2'd1;
      end
    end else if (v1) begin
      dec.byte0 = c1;
      if (v2) begin
        dec.byte1 = c2;
        dec.num   = 2'd2;
      end else begin
        dec.num = 2'd1;
      end
    end else if (v2) begin
      dec.byte0 = c2;
      dec.num   = 2'd1;
    end
  end

endmodule

[hdl/lec_checker.sv]
`include "line_ending_converter_macros.svh"

module lec_checker (
  input logic             clk,
  input logic             rst,
  input logic             pready,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input lec_pkg::result_t result
);

  // A stalled result stays offered
  `LEC_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid, "result dropped while stalled")

  // A stalled result keeps its value
  `LEC_ASSERT(a_result_stable, result_valid && result_stall |=> $stable(result), "stalled result changed")

  // Reset empties the result queue
  `LEC_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid && !item_stall, "queue not empty after reset")

  // The port never inserts wait states
  `LEC_ASSERT(a_pready, pready, "pready low")

endmodule

bind line_ending_converter lec_checker u_lec_checker (.*);
